// ===== design/prefix_function_builder_assert.svh =====
// Assertion macros used by the prefix function builder top level.
`ifndef PREFIX_FUNCTION_BUILDER_ASSERT_SVH
`define PREFIX_FUNCTION_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

`define PFB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("prefix function builder assertion failed");

`define PFB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("prefix function builder assertion failed");

`else

`define PFB_ASSERT(lbl, clk, rst, prop)

`define PFB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== design/pfb_pkg.sv =====
// Types, sizes and helpers of the prefix function builder.
package pfb_pkg;

   localparam int MaxPattern = 4096;
   localparam int AddrWidth  = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
   localparam int PosWidth   = $clog2(MaxPattern + 1);
   localparam int FieldWidth = 12;

   typedef logic [AddrWidth-1:0]  addr_type;
   typedef logic [PosWidth-1:0]   pos_type;
   typedef logic [FieldWidth-1:0] field_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       start_pattern;
      logic       end_of_pattern;
   } req_type;

   typedef struct packed {
      field_type border_length;
      field_type position;
      logic      overflow;
      logic      last_out;
   } rsp_type;

   // Control from the sequencer to the two stores.
   typedef struct packed {
      logic       we;
      addr_type   waddr;
      logic [7:0] wsym;
      addr_type   wborder;
      addr_type   raddr_pat;
      addr_type   raddr_bor;
   } store_ctl_type;

   // Fits a store index into a 12-bit result field, keeping the low bits.
   function automatic field_type to_field(input addr_type value);
      logic [AddrWidth+FieldWidth-1:0] wide;
      wide = {{FieldWidth{1'b0}}, value};
      return wide[FieldWidth-1:0];
   endfunction

endpackage

// ===== design/pfb_store.sv =====
// Pattern and border stores: one write port and one registered read port each.
module pfb_store (
   input  logic                   clock,
   input  pfb_pkg::store_ctl_type store_ctl,
   output logic [7:0]             pat_rdata,
   output pfb_pkg::addr_type      bor_rdata
);

   logic [7:0]        pat_mem [pfb_pkg::MaxPattern];
   pfb_pkg::addr_type bor_mem [pfb_pkg::MaxPattern];

   logic [7:0]        pat_rdata_ff;
   pfb_pkg::addr_type bor_rdata_ff;

   always_ff @(posedge clock) begin
      if (store_ctl.we) begin
         pat_mem[store_ctl.waddr] <= store_ctl.wsym;
         bor_mem[store_ctl.waddr] <= store_ctl.wborder;
      end
      pat_rdata_ff <= pat_mem[store_ctl.raddr_pat];
      bor_rdata_ff <= bor_mem[store_ctl.raddr_bor];
   end

   assign pat_rdata = pat_rdata_ff;
   assign bor_rdata = bor_rdata_ff;

endmodule

// ===== design/prefix_function_builder.sv =====
// Top level of the streaming prefix function (KMP failure value) builder.
//
// Each character item returns one result item with its border length and its
// position in the pattern. An item that extends a pattern moves from IDLE to
// SEARCH, which checks one candidate per fallback step; each step is one
// registered read of the pattern and border memories, so the loop over those
// read ports sets the rate. Fallbacks never outnumber characters. The first
// character of a pattern and a character that arrives once the store is full
// skip the search. A finished result waits in an output register, so the
// next item is taken while it is still held. No clearing pass follows reset:
// entries are always written before they are read within a pattern.
`include "prefix_function_builder_assert.svh"

module prefix_function_builder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfb_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      IDLE,
      SEARCH,
      FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [7:0]              sym_ff, sym_in;
   logic                    last_ff, last_in;
   logic                    ovf_ff, ovf_in;
   pfb_pkg::addr_type       pos_ff, pos_in;
   pfb_pkg::addr_type       k_ff, k_in;
   pfb_pkg::pos_type        next_pos_ff, next_pos_in;
   pfb_pkg::addr_type       match_ff, match_in;
   pfb_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   pfb_pkg::store_ctl_type  store_ctl;
   logic [7:0]              pat_rdata;
   pfb_pkg::addr_type       bor_rdata;

   logic                    accept;
   logic                    out_free;
   pfb_pkg::pos_type        pos_full;
   pfb_pkg::addr_type       match_cur;
   logic                    ovf_cur;
   logic                    immediate;
   logic                    hit;
   logic                    done;
   pfb_pkg::addr_type       k_fin;
   pfb_pkg::addr_type       rd_addr;

   logic                    res_ready;
   logic                    push;
   logic [7:0]              res_sym;
   pfb_pkg::addr_type       res_pos;
   pfb_pkg::addr_type       res_k;
   logic                    res_ovf;
   logic                    res_last;

   pfb_store u_store (
      .clock     (clock),
      .store_ctl (store_ctl),
      .pat_rdata (pat_rdata),
      .bor_rdata (bor_rdata)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == IDLE);
      accept    = req_valid && req_ready;

      // A start flag restarts the pattern before the character is handled.
      pos_full  = req_data.start_pattern ? '0 : next_pos_ff;
      match_cur = req_data.start_pattern ? '0 : match_ff;
      ovf_cur   = (pos_full >= pfb_pkg::pos_type'(pfb_pkg::MaxPattern));
      immediate = ovf_cur || (pos_full == '0);

      hit   = (pat_rdata == sym_ff);
      done  = hit || (k_ff == '0);
      k_fin = hit ? (k_ff + pfb_pkg::addr_type'(1)) : '0;

      res_ready = 1'b0;
      res_sym   = sym_ff;
      res_pos   = pos_ff;
      res_k     = k_ff;
      res_ovf   = ovf_ff;
      res_last  = last_ff;
      case (state_ff)
         IDLE: begin
            res_ready = accept && immediate;
            res_sym   = req_data.symbol;
            res_pos   = pos_full[pfb_pkg::AddrWidth-1:0];
            res_k     = '0;
            res_ovf   = ovf_cur;
            res_last  = req_data.end_of_pattern;
         end
         SEARCH: begin
            res_ready = done;
            res_k     = k_fin;
            res_ovf   = 1'b0;
         end
         FINISH: begin
            res_ready = 1'b1;
         end
         default: begin
            res_ready = 1'b0;
         end
      endcase
      push = res_ready && out_free;

      // The next candidate is read in the cycle that chooses it.
      rd_addr = (state_ff == IDLE) ? match_cur : bor_rdata;

      store_ctl.we        = push && !res_ovf;
      store_ctl.waddr     = res_pos;
      store_ctl.wsym      = res_sym;
      store_ctl.wborder   = res_k;
      store_ctl.raddr_pat = rd_addr;
      store_ctl.raddr_bor = rd_addr - pfb_pkg::addr_type'(1);

      state_in     = state_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      next_pos_in  = next_pos_ff;
      match_in     = match_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               sym_in  = req_data.symbol;
               last_in = req_data.end_of_pattern;
               pos_in  = pos_full[pfb_pkg::AddrWidth-1:0];
               ovf_in  = ovf_cur;
               k_in    = immediate ? '0 : match_cur;
               if (!immediate) begin
                  state_in = SEARCH;
               end else if (!out_free) begin
                  state_in = FINISH;
               end
            end
         end
         SEARCH: begin
            if (done) begin
               k_in     = k_fin;
               state_in = out_free ? IDLE : FINISH;
            end else begin
               k_in = bor_rdata;
            end
         end
         FINISH: begin
            if (out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in          = 1'b1;
         rsp_in.border_length  = pfb_pkg::to_field(res_k);
         rsp_in.position       = res_ovf ? '1 : pfb_pkg::to_field(res_pos);
         rsp_in.overflow       = res_ovf;
         rsp_in.last_out       = res_last;
         if (!res_ovf) begin
            next_pos_in = pfb_pkg::pos_type'(res_pos) + pfb_pkg::pos_type'(1);
            match_in    = res_k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         next_pos_ff  <= '0;
         match_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_pos_ff  <= next_pos_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
         sym_ff       <= sym_in;
         last_ff      <= last_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The running match always stays shorter than the pattern stored so far.
   `PFB_ASSERT(a_match_below_pos, clock, reset, (next_pos_ff != '0) |-> (pfb_pkg::pos_type'(match_ff) < next_pos_ff))
   // A fallback candidate always points at an entry already written.
   `PFB_ASSERT(a_search_in_range, clock, reset, (state_ff == SEARCH) |-> (k_ff < pos_ff))
   // The position counter saturates at the store depth.
   `PFB_ASSERT(a_pos_saturates, clock, reset, accept |-> (next_pos_ff <= pfb_pkg::pos_type'(pfb_pkg::MaxPattern)))
   // An item that needs a search always enters the search state next.
   `PFB_ASSERT(a_search_follows, clock, reset, (accept && !immediate) |=> (state_ff == SEARCH))

endmodule
